// ===== rtl/core/sfmt_pkg.sv =====
package sfmt_pkg;

  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 488;
  localparam int unsigned LEFT_SHIFT    = 18;
  localparam int unsigned RIGHT_SHIFT   = 11;
  localparam int unsigned IDX_W         = 10;

  localparam logic [31:0] SEED_MULT  = 32'h6C078965;
  localparam int unsigned SEED_SHIFT = 30;
  localparam int unsigned C_START    = STATE_WORDS - 8;
  localparam int unsigned LAST_QUAD  = STATE_WORDS - 4;
  localparam int unsigned B_START    = MIDDLE_OFFSET % STATE_WORDS;

  localparam logic [2:0] CFG_MASK0  = 3'd0;
  localparam logic [2:0] CFG_MASK1  = 3'd1;
  localparam logic [2:0] CFG_MASK2  = 3'd2;
  localparam logic [2:0] CFG_MASK3  = 3'd3;
  localparam logic [2:0] CFG_PARITY0 = 3'd4;
  localparam logic [2:0] CFG_PARITY3 = 3'd5;

  typedef enum logic [1:0] {
    CMD_SEED    = 2'd0,
    CMD_NEXT32  = 2'd1,
    CMD_NEXT64  = 2'd2,
    CMD_ADVANCE = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED0,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_CERT,
    ST_RG_LOAD,
    ST_RG_READ,
    ST_RG_CALC,
    ST_RG_WRITE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_ADV
  } state_e;

  typedef enum logic [1:0] {
    RET_SEED,
    RET_READ,
    RET_ADV
  } ret_e;

  typedef logic [3:0][31:0] quad_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] seed_value;
    logic [15:0] frame_count;
  } req_t;

  typedef struct packed {
    logic [63:0] random_value;
    logic [31:0] current_seed;
  } res_t;

endpackage

// ===== rtl/core/sfmt_quad_unit.sv =====
module sfmt_quad_unit
  import sfmt_pkg::*;
(
  input  logic  clk_i,
  input  logic  en_i,
  input  quad_t a_i,
  input  quad_t b_i,
  input  quad_t c_i,
  input  quad_t d_i,
  input  quad_t mask_i,
  output quad_t nw_o
);

  quad_t nw_d, nw_q;
  quad_t a_up, c_dn;

  // carries across word boundaries inside the quad
  assign a_up = a_i << 32;
  assign c_dn = c_i >> 32;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nw_d[k] = a_i[k] ^ (a_i[k] << 8) ^ (a_up[k] >> 24) ^ (c_i[k] >> 8) ^ (c_dn[k] << 24)
              ^ ((b_i[k] >> RIGHT_SHIFT) & mask_i[k]) ^ (d_i[k] << LEFT_SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) nw_q <= nw_d;
  end

  assign nw_o = nw_q;

endmodule

// ===== rtl/core/sfmt_random_generator_unit.sv =====
// SFMT-19937 generator with a 624-word state store.
// Command channel: req_i is taken when start is high and busy is low; busy
// stays high until the word is delivered. Each command gives one result word
// on res_o, marked by valid_o for exactly one cycle; the receiver cannot
// stall, so results are never held back.
// Reads: a 32-bit read passes through states RD0 and RD1, a 64-bit read also
// through RD2, after a regeneration when the store is used up. A regeneration
// walks 156 quads through one shared recursion unit and a store with one read
// and one write port; each quad is read, computed and written back in turn.
// Seed fills the store (one multiply and one add a word), then certifies it
// and runs one regeneration. Advance runs one regeneration for every 624 words
// passed. Configuration: cfg_valid_i/cfg_ready_o write channel, always ready;
// the user must see that it is written only while idle; the block does not
// enforce this. Reset restores mask and parity registers, clears the read
// index and the seed; the store is undefined until seeded.
module sfmt_random_generator_unit
  import sfmt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        valid_o,
  output res_t        res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] mem [STATE_WORDS];

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;
  cmd_e   cmd_q, cmd_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] a_q, a_d;
  logic [IDX_W-1:0] b_q, b_d;
  logic [17:0]      t_q, t_d;
  logic [31:0] seed_q, seed_d;
  logic [31:0] p_q, p_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] w0_q, w0_d;
  logic [31:0] w3_q, w3_d;
  logic [31:0] lo_q, lo_d;
  logic        valid_q, valid_d;
  res_t        res_q, res_d;

  quad_t       mask_q;
  logic [31:0] pw0_q, pw3_q;

  logic [31:0]      rdata_q;
  logic             cap_vld_q;
  logic [3:0]       cap_slot_q;
  logic [15:0][31:0] g_q;

  logic             ren, we, g_shift, calc_en;
  logic [IDX_W-1:0] raddr, waddr;
  logic [3:0]       slot;
  logic [31:0]      wdata, seed_val;
  logic [10:0]      bsum;
  logic             par;
  quad_t            nw;

  sfmt_quad_unit u_quad (
    .clk_i  (clk_i),
    .en_i   (calc_en),
    .a_i    (g_q[3:0]),
    .b_i    (g_q[7:4]),
    .c_i    (g_q[11:8]),
    .d_i    (g_q[15:12]),
    .mask_i (mask_q),
    .nw_o   (nw)
  );

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);
  assign valid_o     = valid_q;
  assign res_o       = res_q;

  assign seed_val = prod_q + {22'd0, i_q};
  assign par      = ^((w0_q & pw0_q) ^ (w3_q & pw3_q));
  assign bsum     = {1'b0, b_q} + {7'd0, cnt_q - 4'd4};

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cmd_d   = cmd_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    i_d     = i_q;
    a_d     = a_q;
    b_d     = b_q;
    t_d     = t_q;
    seed_d  = seed_q;
    p_d     = p_q;
    prod_d  = prod_q;
    w0_d    = w0_q;
    w3_d    = w3_q;
    lo_d    = lo_q;
    valid_d = 1'b0;
    res_d   = res_q;
    ren     = 1'b0;
    raddr   = '0;
    slot    = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    g_shift = 1'b0;
    calc_en = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d = req_i.cmd;
          case (req_i.cmd)
            CMD_SEED: begin
              seed_d  = req_i.seed_value;
              p_d     = req_i.seed_value;
              state_d = ST_SEED0;
            end
            CMD_NEXT32, CMD_NEXT64: begin
              if ((req_i.cmd == CMD_NEXT32 && idx_q >= IDX_W'(STATE_WORDS)) ||
                  (req_i.cmd == CMD_NEXT64 && idx_q >= IDX_W'(STATE_WORDS - 1))) begin
                ret_d   = RET_READ;
                a_d     = '0;
                b_d     = IDX_W'(B_START);
                cnt_d   = '0;
                state_d = ST_RG_LOAD;
              end else begin
                state_d = ST_RD0;
              end
            end
            default: begin
              t_d     = {8'd0, idx_q} + {1'b0, req_i.frame_count, 1'b0};
              state_d = ST_ADV;
            end
          endcase
        end
      end
      ST_SEED0: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = p_q;
        w0_d    = p_q;
        i_d     = IDX_W'(1);
        state_d = ST_SEED_MUL;
      end
      ST_SEED_MUL: begin
        prod_d  = SEED_MULT * (p_q ^ (p_q >> SEED_SHIFT));
        state_d = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = seed_val;
        p_d   = seed_val;
        if (i_q == IDX_W'(3)) w3_d = seed_val;
        if (i_q == IDX_W'(STATE_WORDS - 1)) begin
          state_d = ST_CERT;
        end else begin
          i_d     = i_q + IDX_W'(1);
          state_d = ST_SEED_MUL;
        end
      end
      ST_CERT: begin
        // even parity: flip lowest set bit of the first nonzero parity word
        if (!par) begin
          if (pw0_q != '0) begin
            we    = 1'b1;
            waddr = '0;
            wdata = w0_q ^ (pw0_q & (~pw0_q + 32'd1));
          end else if (pw3_q != '0) begin
            we    = 1'b1;
            waddr = IDX_W'(3);
            wdata = w3_q ^ (pw3_q & (~pw3_q + 32'd1));
          end
        end
        ret_d   = RET_SEED;
        a_d     = '0;
        b_d     = IDX_W'(B_START);
        cnt_d   = '0;
        state_d = ST_RG_LOAD;
      end
      ST_RG_LOAD: begin
        // prime the two trailing quads from the end of the store
        if (cnt_q < 4'd8) begin
          ren   = 1'b1;
          raddr = IDX_W'(C_START) + {6'd0, cnt_q};
          slot  = cnt_q + 4'd8;
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd8) begin
          cnt_d   = '0;
          state_d = ST_RG_READ;
        end
      end
      ST_RG_READ: begin
        if (cnt_q < 4'd4) begin
          ren   = 1'b1;
          raddr = a_q + {6'd0, cnt_q};
          slot  = cnt_q;
        end else if (cnt_q < 4'd8) begin
          ren   = 1'b1;
          raddr = (bsum >= 11'(STATE_WORDS)) ? IDX_W'(bsum - 11'(STATE_WORDS))
                                             : bsum[IDX_W-1:0];
          slot  = cnt_q;
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd8) begin
          cnt_d   = '0;
          state_d = ST_RG_CALC;
        end
      end
      ST_RG_CALC: begin
        calc_en = 1'b1;
        state_d = ST_RG_WRITE;
      end
      ST_RG_WRITE: begin
        we    = 1'b1;
        waddr = a_q + {8'd0, cnt_q[1:0]};
        wdata = nw[cnt_q[1:0]];
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd3) begin
          g_shift = 1'b1;
          cnt_d   = '0;
          a_d     = a_q + IDX_W'(4);
          b_d     = ({1'b0, b_q} + 11'd4 >= 11'(STATE_WORDS))
                    ? IDX_W'({1'b0, b_q} + 11'd4 - 11'(STATE_WORDS)) : b_q + IDX_W'(4);
          if (a_q == IDX_W'(LAST_QUAD)) begin
            case (ret_q)
              RET_SEED: begin
                idx_d   = '0;
                valid_d = 1'b1;
                res_d   = '{random_value: 64'd0, current_seed: seed_q};
                state_d = ST_IDLE;
              end
              RET_READ: begin
                idx_d   = '0;
                state_d = ST_RD0;
              end
              default: state_d = ST_ADV;
            endcase
          end else begin
            state_d = ST_RG_READ;
          end
        end
      end
      ST_RD0: begin
        ren     = 1'b1;
        raddr   = idx_q;
        state_d = ST_RD1;
      end
      ST_RD1: begin
        lo_d = rdata_q;
        if (cmd_q == CMD_NEXT64) begin
          ren     = 1'b1;
          raddr   = idx_q + IDX_W'(1);
          state_d = ST_RD2;
        end else begin
          valid_d = 1'b1;
          res_d   = '{random_value: {32'd0, rdata_q}, current_seed: seed_q};
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_IDLE;
        end
      end
      ST_RD2: begin
        valid_d = 1'b1;
        res_d   = '{random_value: {rdata_q, lo_q}, current_seed: seed_q};
        idx_d   = idx_q + IDX_W'(2);
        state_d = ST_IDLE;
      end
      ST_ADV: begin
        if (t_q >= 18'(STATE_WORDS)) begin
          t_d     = t_q - 18'(STATE_WORDS);
          ret_d   = RET_ADV;
          a_d     = '0;
          b_d     = IDX_W'(B_START);
          cnt_d   = '0;
          state_d = ST_RG_LOAD;
        end else begin
          idx_d   = t_q[IDX_W-1:0];
          valid_d = 1'b1;
          res_d   = '{random_value: 64'd0, current_seed: seed_q};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= RET_SEED;
      cnt_q     <= '0;
      idx_q     <= '0;
      seed_q    <= '0;
      valid_q   <= 1'b0;
      cap_vld_q <= 1'b0;
      mask_q    <= {32'hBFFFFFF6, 32'hBFFAFFFF, 32'hDDFECB7F, 32'hDFFFFFEF};
      pw0_q     <= 32'h00000001;
      pw3_q     <= 32'h13C9E684;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      seed_q    <= seed_d;
      valid_q   <= valid_d;
      cap_vld_q <= ren;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MASK0:   mask_q[0] <= cfg_data_i;
          CFG_MASK1:   mask_q[1] <= cfg_data_i;
          CFG_MASK2:   mask_q[2] <= cfg_data_i;
          CFG_MASK3:   mask_q[3] <= cfg_data_i;
          CFG_PARITY0: pw0_q     <= cfg_data_i;
          CFG_PARITY3: pw3_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    i_q        <= i_d;
    a_q        <= a_d;
    b_q        <= b_d;
    t_q        <= t_d;
    p_q        <= p_d;
    prod_q     <= prod_d;
    w0_q       <= w0_d;
    w3_q       <= w3_d;
    lo_q       <= lo_d;
    res_q      <= res_d;
    cap_slot_q <= slot;
    if (cap_vld_q) g_q[cap_slot_q] <= rdata_q;
    // the new quad becomes the last one, the old last one moves back
    if (g_shift) begin
      g_q[11:8]  <= g_q[15:12];
      g_q[15:12] <= nw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (ren) rdata_q <= mem[raddr];
  end

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result word without a command in flight");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(STATE_WORDS))
    else $error("read index beyond the store");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not start");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> busy)
    else $error("store written while idle");

endmodule
